>>> rtl/assert_macros.svh
// Assertion macros shared by the awning guard RTL.
// Empty bodies when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/awg_pkg.sv
// Package for the awning guard: beat types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package awg_pkg;
  localparam int unsigned GustSlotsDef = 4;
  localparam logic [1:0] KindPoll = 2'd0;
  localparam logic [1:0] KindTick = 2'd1;
  localparam logic [1:0] KindReport = 2'd2;
  localparam logic [1:0] MoveNone = 2'd0;
  localparam logic [1:0] MoveRaise = 2'd1;
  localparam logic [1:0] MoveLower = 2'd2;
  localparam logic [1:0] RegGust = 2'd0;
  localparam logic [1:0] RegRain = 2'd1;
  localparam logic [1:0] RegAuto = 2'd2;
  localparam logic [5:0] WindBase = 6'd39;
  localparam logic [15:0] SetpointOffs = 16'd8192;
  localparam logic [16:0] Step1000 = 17'd1000;
  localparam logic [17:0] Margin5000 = 18'd5000;

  typedef struct packed {
    logic [1:0]  kind;
    logic        button_pressed;
    logic [15:0] wind_pulses;
    logic        tick_gap;
    logic [15:0] wet_after;
    logic [15:0] wet_before;
    logic [15:0] wind_knob;
    logic [15:0] rain_knob;
    logic        move_interrupted;
  } in_beat_t;

  typedef struct packed {
    logic        warning;
    logic        alarm;
    logic [1:0]  move_request;
    logic        tent_is_down;
    logic        auto_mode;
    logic [15:0] rain_threshold;
    logic [15:0] wet_ratio;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic slot_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic slot_last;
  } sts_t;
endpackage

>>> rtl/awg_ctrl.sv
// Sequencer for the awning guard: handshake and step control.
// Depends on awg_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module awg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  awg_pkg::sts_t  sts_i,
  output awg_pkg::cmd_t  cmd_o
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StSlot = 5'b00100,
    StFin  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StSlot;
        end
      end
      StSlot: begin
        cmd_o.slot_step = 1'b1;
        if (sts_i.slot_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_NEXT(a_load_div, clk_i, rst_ni, cmd_o.load, state_q == StDiv)
  `ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, cmd_o.finish, out_valid_q)
  `ASSERT_IMPL(a_one_cmd, clk_i, rst_ni, $onehot0(cmd_o))
endmodule

>>> rtl/awg_dp.sv
// Datapath for the awning guard: serial divider, gust slot walk, state update.
// Depends on awg_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module awg_dp #(
  parameter int unsigned GustSlots = awg_pkg::GustSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awg_pkg::in_beat_t   in_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  awg_pkg::cmd_t       cmd_i,
  output awg_pkg::sts_t       sts_o,
  output awg_pkg::out_beat_t  out_o
);
  localparam int unsigned SlotW = (GustSlots > 1) ? $clog2(GustSlots) : 1;
  localparam int unsigned CntW = $clog2(GustSlots + 1);

  logic [7:0]  gust_win_q, rain_sec_q;
  logic [15:0] auto_sec_q;
  logic        down_q, auto_q, down_d, auto_d;
  logic [15:0] thr_q, thr_d, sp_last_q, sp_blast_q, low_q, low_d, ratio_q;
  logic [7:0]  wet_q, wet_d;
  logic [7:0]  gust_q [GustSlots];
  logic [15:0] cd_q, cd_d;
  logic [1:0]  pend_q, pend_d;
  awg_pkg::in_beat_t b_q;
  awg_pkg::out_beat_t out_q, out_d;
  logic        act_q, clr_q;
  // divider
  logic [31:0] rem_q;
  logic [16:0] quo_q;
  logic [4:0]  dcnt_q;
  // slot walk
  logic [SlotW-1:0] scnt_q;
  logic [CntW-1:0]  busy_q;
  logic [SlotW-1:0] free_q;
  logic [32:0] shifted;
  logic [32:0] trial;

  // first step takes the overflow bit without a shift
  assign shifted = (dcnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign trial = shifted - {17'd0, b_q.wet_before};
  assign sts_o.div_last = (dcnt_q == 5'd16);
  assign sts_o.slot_last = (scnt_q == SlotW'(GustSlots - 1));
  assign out_o = out_q;

  // tick arithmetic
  logic [7:0]  delta;
  logic [5:0]  limit;
  logic        wind_over, rain_pre, alarm, pressed, is_tick;
  logic [15:0] ratio, sp;
  logic [16:0] diffp, diffn;
  logic        tick_alarm_rain;
  logic [1:0]  req;
  logic [7:0]  wet_base;

  always_comb begin
    delta = (b_q.tick_gap) ? 8'd0 :
            ((b_q.wind_pulses > 16'd255) ? 8'd255 : b_q.wind_pulses[7:0]);
    limit = awg_pkg::WindBase - {1'b0, b_q.wind_knob[15:11]};
    wind_over = {2'b0, limit} < delta;
    ratio = (b_q.wet_before == 16'd0) ? 16'hFFFF :
            (quo_q[16] ? 16'hFFFF : quo_q[15:0]);
    rain_pre = ratio < thr_q;
    sp = {1'b0, b_q.rain_knob[15:1]} + awg_pkg::SetpointOffs;
    diffp = {1'b0, sp} - {1'b0, sp_blast_q};
    diffn = {1'b0, sp_blast_q} - {1'b0, sp};
  end

  always_comb begin
    logic [15:0] t;
    logic [16:0] rm;
    t = thr_q;
    low_d = low_q;
    if (({1'b0, sp} > {1'b0, sp_blast_q} && diffp > awg_pkg::Step1000) ||
        ({1'b0, sp_blast_q} > {1'b0, sp} && diffn > awg_pkg::Step1000)) begin
      t = sp;
    end
    rm = {1'b0, ratio} - awg_pkg::Step1000;
    if (down_q) begin
      if (pressed) begin
        t = rm[16] ? 16'd0 : rm[15:0];
        if (t > sp) t = sp;
      end else begin
        if (t < sp) begin
          if ({2'b0, ratio} > {2'b0, sp} + awg_pkg::Margin5000) t = sp;
          else if ({2'b0, ratio} > {2'b0, t} + awg_pkg::Margin5000)
            t = t + awg_pkg::Step1000[15:0];
        end else begin
          t = sp;
        end
        low_d = 16'hFFFF;
      end
    end else if (auto_q) begin
      if (ratio < low_q) begin
        low_d = ratio;
        t = {1'b0, sp[15:1]} + {1'b0, ratio[15:1]};
      end
    end else begin
      t = sp;
    end
    thr_d = t;
  end

  always_comb begin
    wet_base = clr_q ? 8'd0 : wet_q;
    wet_d = rain_pre ? ((wet_base == 8'd255) ? 8'd255 : wet_base + 8'd1) : 8'd0;
    tick_alarm_rain = wet_d >= rain_sec_q;
    alarm = tick_alarm_rain ||
            (wind_over && (busy_q >= CntW'(GustSlots)));
    down_d = down_q;
    auto_d = auto_q;
    cd_d = cd_q;
    pend_d = pend_q;
    req = awg_pkg::MoveNone;
    if (down_q) begin
      if (alarm) begin
        pend_d = awg_pkg::MoveRaise;
        req = awg_pkg::MoveRaise;
      end
    end else if (alarm) begin
      cd_d = auto_sec_q;
    end else if (auto_q) begin
      if (cd_q != 16'd0) cd_d = cd_q - 16'd1;
      else begin
        pend_d = awg_pkg::MoveLower;
        req = awg_pkg::MoveLower;
      end
    end
    out_d = '0;
    out_d.tent_is_down = down_q;
    out_d.auto_mode = auto_q;
    out_d.rain_threshold = thr_q;
    out_d.wet_ratio = ratio_q;
    if (is_tick) begin
      out_d.warning = wind_over || rain_pre;
      out_d.alarm = alarm;
      out_d.move_request = req;
      out_d.rain_threshold = thr_d;
      out_d.wet_ratio = ratio;
    end
  end

  assign is_tick = act_q && (b_q.kind == awg_pkg::KindTick);
  assign pressed = b_q.button_pressed;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      b_q <= in_i;
      rem_q <= {16'd0, in_i.wet_after};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
      quo_q <= {quo_q[15:0], ~trial[32]};
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gust_win_q <= 8'd60;
      rain_sec_q <= 8'd10;
      auto_sec_q <= 16'd14400;
      down_q <= 1'b1;
      auto_q <= 1'b1;
      thr_q <= '0;
      sp_last_q <= '0;
      sp_blast_q <= '0;
      low_q <= 16'hFFFF;
      wet_q <= '0;
      cd_q <= '0;
      pend_q <= awg_pkg::MoveNone;
      ratio_q <= '0;
      act_q <= 1'b0;
      clr_q <= 1'b0;
      dcnt_q <= '0;
      scnt_q <= '0;
      busy_q <= '0;
      free_q <= '0;
      for (int i = 0; i < GustSlots; i++) gust_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          awg_pkg::RegGust: gust_win_q <= cfg_data_i[7:0];
          awg_pkg::RegRain: rain_sec_q <= cfg_data_i[7:0];
          awg_pkg::RegAuto: auto_sec_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        dcnt_q <= '0;
        scnt_q <= '0;
        busy_q <= '0;
        free_q <= '0;
        act_q <= 1'b0;
        clr_q <= 1'b0;
        if (in_i.kind == awg_pkg::KindReport) begin
          if (pend_q == awg_pkg::MoveRaise) begin
            if (in_i.move_interrupted) auto_q <= 1'b0;
            else begin
              down_q <= 1'b0;
              cd_q <= auto_sec_q;
            end
            clr_q <= 1'b1;
          end else if (pend_q == awg_pkg::MoveLower) begin
            if (in_i.move_interrupted) auto_q <= 1'b0;
            down_q <= 1'b1;
            clr_q <= 1'b1;
          end
          pend_q <= awg_pkg::MoveNone;
        end else if ((in_i.kind == awg_pkg::KindPoll || in_i.kind == awg_pkg::KindTick)
                     && pend_q == awg_pkg::MoveNone) begin
          act_q <= 1'b1;
          if (in_i.button_pressed) begin
            auto_q <= 1'b0;
            down_q <= 1'b1;
            clr_q <= 1'b1;
          end
        end
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 5'd1;
      end
      if (cmd_i.slot_step) begin
        if (!sts_o.slot_last) scnt_q <= scnt_q + SlotW'(1);
        if (clr_q) begin
          gust_q[scnt_q] <= '0;
          if (is_tick) free_q <= scnt_q;
        end else if (is_tick) begin
          if (gust_q[scnt_q] != 8'd0) begin
            gust_q[scnt_q] <= gust_q[scnt_q] - 8'd1;
            busy_q <= busy_q + CntW'(1);
          end else begin
            free_q <= scnt_q;
          end
        end
      end
      if (cmd_i.finish) begin
        if (is_tick) begin
          ratio_q <= ratio;
          thr_q <= thr_d;
          low_q <= low_d;
          sp_blast_q <= sp_last_q;
          sp_last_q <= sp;
          wet_q <= wet_d;
          down_q <= down_d;
          auto_q <= auto_d;
          cd_q <= cd_d;
          pend_q <= pend_d;
          if (wind_over && busy_q < CntW'(GustSlots)) gust_q[free_q] <= gust_win_q;
        end else if (clr_q) begin
          wet_q <= '0;
        end
      end
    end
  end

  `ASSERT_IMPL(a_busy_range, clk_i, rst_ni, busy_q <= CntW'(GustSlots))
  `ASSERT_IMPL(a_pend_code, clk_i, rst_ni, pend_q != 2'd3)
  `ASSERT_NEXT(a_pend_ack, clk_i, rst_ni,
    cmd_i.load && in_i.kind == awg_pkg::KindReport, pend_q == awg_pkg::MoveNone)
endmodule

>>> rtl/awning_wind_rain_guard.sv
// Awning guard: each beat runs through the 17-step restoring divider and the walk
// over the gust slots before its result is registered; one beat at a time, and no
// new beat is taken until the previous one has left the finish state.
// Result waits in an output register; the next result is stored once it has left.
// Asynchronous active-low reset restores the register defaults and flags.
`timescale 1ns / 1ps
module awning_wind_rain_guard #(
  parameter int unsigned GUST_SLOTS = awg_pkg::GustSlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  awg_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output awg_pkg::out_beat_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  awg_pkg::cmd_t cmd;
  awg_pkg::sts_t sts;

  awg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  awg_dp #(.GustSlots(GUST_SLOTS)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );
endmodule
